// ===== hw/rtl/ppt_pkg.sv =====
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared types and constants for the pending ping table: item layouts,
// the stored entry, control bundle for the cell chain and the state codes.
// ----------------------------------------------------------------------------
package ppt_pkg;

    // Default number of table entries and timeout after reset.
    localparam int DEPTH_DEFAULT = 256;
    localparam logic [15:0] TIMEOUT_RESET = 16'd5;

    // Action codes carried in the input item.
    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // One input item.
    typedef struct packed {
        logic        action;
        logic [31:0] peer_ip;
        logic [15:0] peer_port;
        logic [63:0] ping_ident;
        logic [63:0] current_time;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic        found;
        logic [63:0] stored_ident;
    } t_out_item;

    // One pending ping as held by a cell.
    typedef struct packed {
        logic [31:0] ip;
        logic [15:0] port;
        logic [63:0] ident;
        logic [63:0] stamp;
    } t_entry;

    // Control that goes to every cell of the chain.
    typedef struct packed {
        logic shift;    // every cell takes its right neighbor's entry
        logic load;     // the selected cell takes the new entry
    } t_chain_ctrl;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_DROP,
        S_SCAN,
        S_RESULT
    } t_state;

endpackage

// ===== hw/rtl/ppt_cell.sv =====
// ----------------------------------------------------------------------------
// ppt_cell
// One storage cell of the chain. It holds a single entry and either keeps
// it, takes its right neighbor's entry, or loads a newly added entry.
// ----------------------------------------------------------------------------
module ppt_cell
    import ppt_pkg::*;
(
    input  logic        i_clk,
    input  t_chain_ctrl i_ctrl,
    input  logic        i_load_sel,
    input  t_entry      i_nbr,
    input  t_entry      i_new,
    output t_entry      o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    // A load into this cell wins over the shift from the neighbor.
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.load && i_load_sel) begin
            n_entry = i_new;
        end else if (i_ctrl.shift) begin
            n_entry = i_nbr;
        end
    end

    // Entry storage; contents are undefined until written.
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== hw/rtl/ppt_chain.sv =====
// ----------------------------------------------------------------------------
// ppt_chain
// Ring of entry cells, oldest entry in cell 0. A shift rotates the ring by
// one position toward cell 0, so the head cell sees every entry in turn.
// ----------------------------------------------------------------------------
module ppt_chain
    import ppt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
    input  logic                           i_clk,
    input  t_chain_ctrl                    i_ctrl,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_load_idx,
    input  t_entry                         i_new,
    output t_entry                         o_head
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    t_entry w_entry [TABLE_DEPTH];

    // Each cell takes its right neighbor; the last cell wraps to cell 0.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        ppt_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (i_ctrl),
            .i_load_sel (i_load_idx == IDX_W'(g)),
            .i_nbr      (w_entry[(g + 1) % TABLE_DEPTH]),
            .i_new      (i_new),
            .o_entry    (w_entry[g])
        );
    end

    assign o_head = w_entry[0];

endmodule

// ===== hw/rtl/pending_ping_table.sv =====
// Operation: an add first drops expired entries at the head cell, one per
// cycle, then writes; a query drops them too and then turns the whole ring
// past the head; a query with address and id both zero skips both steps.
// One item at a time: the next item is taken only after the last one's result
// is registered, and later while an earlier result is stalled.
// Reset clears live count, state and handshake; timeout becomes 5.
// ----------------------------------------------------------------------------
// pending_ping_table
// Table of outstanding pings kept in a ring of cells, oldest first, with
// expiry of stale entries, add with overwrite of the oldest, and lookup.
// ----------------------------------------------------------------------------
module pending_ping_table
    import ppt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    t_state            r_state, n_state;
    t_in_item          r_item, n_item;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_rot, n_rot;
    logic              r_found, n_found;
    logic [15:0]       r_timeout;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    t_chain_ctrl       w_ctrl;
    logic [IDX_W-1:0]  w_load_idx;
    t_entry            w_new;
    t_entry            w_head;
    logic [63:0]       w_age;
    logic              w_expired;
    logic              w_match;
    logic              w_full;

    // Entry storage.
    ppt_chain #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_chain (
        .i_clk      (i_clk),
        .i_ctrl     (w_ctrl),
        .i_load_idx (w_load_idx),
        .i_new      (w_new),
        .o_head     (w_head)
    );

    // New entry built from the item being worked on.
    assign w_new.ip    = r_item.peer_ip;
    assign w_new.port  = r_item.peer_port;
    assign w_new.ident = r_item.ping_ident;
    assign w_new.stamp = r_item.current_time;

    // Expiry test on the head cell, exact and without wrap.
    assign w_age     = r_item.current_time - w_head.stamp;
    assign w_expired = (r_item.current_time > w_head.stamp)
                       && (w_age > {48'd0, r_timeout});

    // Match test on the head cell.
    assign w_match = ((r_item.peer_ip == 32'd0)
                      || ((w_head.ip == r_item.peer_ip) && (w_head.port == r_item.peer_port)))
                     && ((r_item.ping_ident == 64'd0) || (w_head.ident == r_item.ping_ident));

    assign w_full = (r_count == CNT_W'(TABLE_DEPTH));

    // Next state and datapath control.
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_count     = r_count;
        n_rot       = r_rot;
        n_found     = r_found;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_ctrl      = '0;
        w_load_idx  = r_count[IDX_W-1:0];

        // The held result leaves when the consumer takes it.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_item;
                    n_found = 1'b0;
                    if ((i_in_item.action == ACT_QUERY) && (i_in_item.peer_ip == 32'd0)
                        && (i_in_item.ping_ident == 64'd0)) begin
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_DROP;
                    end
                end
            end
            S_DROP: begin
                if ((r_count != '0) && w_expired) begin
                    // Drop the oldest entry by rotating it away from the head.
                    w_ctrl.shift = 1'b1;
                    n_count      = r_count - CNT_W'(1);
                end else if (r_item.action == ACT_ADD) begin
                    w_ctrl.load = 1'b1;
                    if (w_full) begin
                        // Discard the oldest and write the new entry at the tail.
                        w_ctrl.shift = 1'b1;
                        w_load_idx   = IDX_W'(TABLE_DEPTH - 1);
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                    n_state = S_RESULT;
                end else begin
                    n_rot   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // A full turn of the ring brings every entry past the head.
                w_ctrl.shift = 1'b1;
                if ((CNT_W'(r_rot) < r_count) && w_match) begin
                    n_found = 1'b1;
                end
                if (r_rot == IDX_W'(TABLE_DEPTH - 1)) begin
                    n_state = S_RESULT;
                end else begin
                    n_rot = r_rot + IDX_W'(1);
                end
            end
            S_RESULT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    if (r_item.action == ACT_ADD) begin
                        n_out.found        = 1'b0;
                        n_out.stored_ident = r_item.ping_ident;
                    end else begin
                        n_out.found        = r_found;
                        n_out.stored_ident = 64'd0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_timeout   <= TIMEOUT_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_rot   <= n_rot;
        r_found <= n_found;
        r_out   <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pending ping table. A ping_checker object keeps
// its own copy of the ring and the timeout, works out the reply for every
// accepted item and compares each reply that leaves the block against it.
// Stimulus is a directed opening followed by several random phases, each
// with its own timeout, mix of adds and queries, and pace of time.
// ----------------------------------------------------------------------------
module tb_top
    import ppt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;

    // Tracks the live pings the block should hold and the replies it still owes.
    class ping_checker;
        t_entry      ring [DEPTH_DEFAULT];
        int unsigned head;
        int unsigned count;
        logic [15:0] timeout;
        t_out_item   replies_due [$];
        int unsigned errors;

        function new();
            head    = 0;
            count   = 0;
            timeout = TIMEOUT_RESET;
            errors  = 0;
        endfunction

        // Exact age test, no wrap: only a stamp in the past can go stale.
        function bit is_stale(logic [63:0] stamp, logic [63:0] now_s);
            return (now_s > stamp) && ((now_s - stamp) > 64'(timeout));
        endfunction

        // Drops stale pings from the oldest end, stopping at the first live one.
        function void drop_stale(logic [63:0] now_s);
            while (count > 0 && is_stale(ring[head].stamp, now_s)) begin
                head = (head + 1) % DEPTH_DEFAULT;
                count--;
            end
        endfunction

        function t_entry entry_at(int unsigned offset);
            return ring[(head + offset) % DEPTH_DEFAULT];
        endfunction

        // Updates the table for one item and returns the reply it owes.
        function t_out_item predict_reply(t_in_item it);
            t_out_item reply;
            t_entry    e;
            bit        peer_ok;
            bit        id_ok;
            reply = '0;
            if (it.action == ACT_ADD) begin
                drop_stale(it.current_time);
                // A full ring loses its oldest ping to make room.
                if (count >= DEPTH_DEFAULT) begin
                    count = DEPTH_DEFAULT - 1;
                    head  = (head + 1) % DEPTH_DEFAULT;
                end
                e.ip    = it.peer_ip;
                e.port  = it.peer_port;
                e.ident = it.ping_ident;
                e.stamp = it.current_time;
                ring[(head + count) % DEPTH_DEFAULT] = e;
                count++;
                reply.stored_ident = it.ping_ident;
            end else if (it.peer_ip != '0 || it.ping_ident != '0) begin
                // A query with both address and id zero touches nothing.
                drop_stale(it.current_time);
                for (int unsigned k = 0; k < count; k++) begin
                    e       = entry_at(k);
                    peer_ok = (it.peer_ip == '0) ||
                              (e.ip == it.peer_ip && e.port == it.peer_port);
                    id_ok   = (it.ping_ident == '0) || (e.ident == it.ping_ident);
                    if (peer_ok && id_ok) begin
                        reply.found = 1'b1;
                        break;
                    end
                end
            end
            return reply;
        endfunction

        function void note_ping_item(t_in_item it);
            replies_due.push_back(predict_reply(it));
        endfunction

        // Compares one reply with the oldest one owed.
        function void check_reply(t_out_item got);
            t_out_item want;
            if (replies_due.size() == 0) begin
                $error("unexpected reply: found %0d, stored_ident 0x%0h",
                       got.found, got.stored_ident);
                errors++;
                return;
            end
            want = replies_due.pop_front();
            if (got.found !== want.found) begin
                $error("found: expected %0d, actual %0d", want.found, got.found);
                errors++;
            end
            if (got.stored_ident !== want.stored_ident) begin
                $error("stored_ident: expected 0x%0h, actual 0x%0h",
                       want.stored_ident, got.stored_ident);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return replies_due.size();
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_item   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_item;

    ping_checker chk;
    logic [63:0] ping_now    = '0;
    bit          idling      = 1'b0;
    int unsigned stall_left  = 0;
    int unsigned cycle_count = 0;
    logic [31:0] ip_pool [4] = '{32'hFFFF_FFFF, 32'h0000_0001, 32'hC0A8_0001, 32'h0A00_0001};

    pending_ping_table #(
        .TABLE_DEPTH(DEPTH_DEFAULT)
    ) DUT (
        .*
    );

    // Clock: 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver side: stalls come in bursts of random length while idling is on.
    always @(posedge i_clk) begin
        if (!idling) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if ($urandom_range(0, 11) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 16);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Every reply taken from the block is checked.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            chk.check_reply(o_out_item);
        end
    end

    // Guard against a hung block.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offers one item and returns at the edge that accepts it; valid stays high.
    task automatic send_item(input t_in_item it);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        chk.note_ping_item(it);
    endtask

    task automatic idle_cycles(input int unsigned n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Holds off the sender until every owed reply has come back.
    task automatic drain_replies();
        i_in_valid <= 1'b0;
        while (chk.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        chk.timeout = value;
    endtask

    task automatic ping(input logic act, input logic [31:0] ip, input logic [15:0] port,
                        input logic [63:0] ident, input logic [63:0] t);
        t_in_item it;
        it.action       = act;
        it.peer_ip      = ip;
        it.peer_port    = port;
        it.ping_ident   = ident;
        it.current_time = t;
        ping_now        = t;
        send_item(it);
    endtask

    // Random item; most queries are built from a live ping so that they can hit.
    function automatic t_in_item make_item(int unsigned add_pct, int unsigned step_max);
        t_in_item    it;
        t_entry      e;
        int unsigned pick;
        it.action     = ($urandom_range(0, 99) < add_pct) ? ACT_ADD : ACT_QUERY;
        it.peer_ip    = ($urandom_range(0, 7) == 0) ? ip_pool[$urandom_range(0, 3)]
                                                    : 32'($urandom);
        it.peer_port  = ($urandom_range(0, 3) == 0) ? 16'd80 : 16'($urandom);
        it.ping_ident = {$urandom, $urandom};
        if ($urandom_range(0, 31) == 0) it.ping_ident = '0;
        if (it.action == ACT_QUERY) begin
            pick = $urandom_range(0, 99);
            if (pick < 65 && chk.count > 0) begin
                e = chk.entry_at($urandom_range(0, chk.count - 1));
                it.peer_ip    = e.ip;
                it.peer_port  = e.port;
                it.ping_ident = e.ident;
                case ($urandom_range(0, 5))
                    0: it.peer_ip = '0;
                    1: it.ping_ident = '0;
                    2: it.peer_port ^= 16'(1 << $urandom_range(0, 15));
                    3: it.ping_ident ^= 64'(1) << $urandom_range(0, 63);
                    default: ;
                endcase
            end else if (pick < 72) begin
                it.peer_ip    = '0;
                it.ping_ident = '0;
            end else if (pick < 78) begin
                it.peer_ip = '0;
            end
        end
        // Time mostly creeps forward, now and then it steps back.
        if ($urandom_range(0, 99) < 3) begin
            ping_now = ping_now - $urandom_range(1, 20);
        end else begin
            ping_now = ping_now + $urandom_range(0, step_max);
        end
        it.current_time = ping_now;
        return it;
    endfunction

    // One random phase under its own timeout.
    task automatic run_phase(input logic [15:0] tmo, input int unsigned items,
                             input int unsigned add_pct, input int unsigned step_max,
                             input bit with_idle, input bit fresh_base);
        drain_replies();
        write_timeout(tmo);
        idling = with_idle;
        if (fresh_base) ping_now = {$urandom, $urandom};
        for (int unsigned n = 0; n < items; n++) begin
            if (with_idle && $urandom_range(0, 6) == 0) idle_cycles($urandom_range(1, 17));
            if ($urandom_range(0, 99) == 0) drain_replies();
            send_item(make_item(add_pct, step_max));
        end
    endtask

    initial begin
        chk = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idling = 1'b1;

        // Directed opening under the reset timeout of 5.
        ping(ACT_QUERY, 32'h0A00_0001, 16'd80, 64'h1234, 64'd0);
        ping(ACT_QUERY, 32'h0, 16'h0, 64'h0, 64'd0);
        ping(ACT_ADD, 32'hFFFF_FFFF, 16'hFFFF, '1, 64'd0);
        ping(ACT_ADD, 32'h1, 16'h0, 64'h0, 64'd0);
        ping(ACT_ADD, 32'h0, 16'h1F90, 64'h8000_0000_0000_0001, 64'd0);
        ping(ACT_ADD, 32'h0A00_0001, 16'd80, 64'h1234, 64'd3);
        ping(ACT_QUERY, 32'h0A00_0001, 16'd80, 64'h1234, 64'd5);
        ping(ACT_QUERY, 32'h0A00_0001, 16'd81, 64'h1234, 64'd5);
        ping(ACT_QUERY, 32'h0, 16'd7, 64'h1234, 64'd5);
        ping(ACT_QUERY, 32'h0A00_0001, 16'd80, 64'h0, 64'd5);
        ping(ACT_QUERY, 32'h1, 16'h0, 64'h0, 64'd5);
        // Wildcard query far in the future must not expire anything.
        ping(ACT_QUERY, 32'h0, 16'h0, 64'h0, 64'd1000);
        // Age equal to the timeout keeps a ping, one more drops it.
        ping(ACT_QUERY, 32'hFFFF_FFFF, 16'hFFFF, '1, 64'd5);
        ping(ACT_QUERY, 32'hFFFF_FFFF, 16'hFFFF, '1, 64'd6);
        ping(ACT_QUERY, 32'h0, 16'h0, 64'h1234, 64'd6);
        // Time going backwards.
        ping(ACT_ADD, 32'h2, 16'h2, 64'h55, 64'd2);
        ping(ACT_QUERY, 32'h2, 16'h2, 64'h55, 64'd2);
        ping(ACT_QUERY, 32'h0, 16'h0, 64'h55, 64'd9);
        // Largest time stamp.
        ping(ACT_ADD, 32'hDEAD_BEEF, 16'h5A5A, 64'hAAAA_AAAA_AAAA_AAAA, '1);
        ping(ACT_QUERY, 32'h0, 16'h0, 64'hAAAA_AAAA_AAAA_AAAA, '1);
        ping(ACT_QUERY, 32'hDEAD_BEEF, 16'h5A5A, 64'h0, '1);
        ping(ACT_ADD, 32'h3, 16'h3, 64'h5555_5555_5555_5555, 64'd0);
        ping(ACT_QUERY, 32'h3, 16'h3, 64'h5555_5555_5555_5555, 64'd100);

        // Longest timeout, add-heavy so the ring fills and wraps.
        run_phase(16'hFFFF, 350, 85, 2, 1'b1, 1'b0);
        ping(ACT_QUERY, 32'h0, 16'h0, {$urandom, $urandom}, ping_now + 64'd65535);
        ping(ACT_QUERY, 32'h0, 16'h0, {$urandom, $urandom}, ping_now + 64'd65936);

        // Zero timeout: the ring starts empty, as the far-future queries above expired every ping.
        run_phase(16'h0000, 110, 50, 1, 1'b1, 1'b0);
        run_phase(16'h0001, 110, 55, 2, 1'b0, 1'b0);
        run_phase(16'($urandom_range(2, 40)), 110, 50, 6, 1'b1, 1'b1);
        // Closing stretch back at the reset timeout, with no idling.
        run_phase(TIMEOUT_RESET, 100, 50, 3, 1'b0, 1'b0);

        drain_replies();
        repeat (20) @(posedge i_clk);
        if (chk.errors == 0 && chk.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
